### rtl/ratalu_pkg.sv
// Package: shared types and constants of the rational ALU.
`default_nettype none
package ratalu_pkg;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned MagWidth = 2 * OperandWidth;
  localparam int unsigned ShWidth = $clog2(MagWidth + 1);

  typedef enum logic [1:0] {
    KindAdd = 2'd0,
    KindSub = 2'd1,
    KindMul = 2'd2,
    KindDiv = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk = 2'd0,
    StatusZeroDen = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  // classified work item handed from front to back
  typedef struct packed {
    logic [MagWidth-1:0] num_mag;
    logic num_neg;
    logic [MagWidth-1:0] den_mag;
    logic den_neg;
  } work_t;
endpackage
`default_nettype wire

### rtl/ratalu_front.sv
// Front end: accepts items and forms the unreduced cross products.
`default_nettype none
module ratalu_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [31:0] num_a_i,
  input  wire logic [31:0] den_a_i,
  input  wire logic [31:0] num_b_i,
  input  wire logic [31:0] den_b_i,
  output logic wr_valid_o,
  input  wire logic wr_ready_i,
  output ratalu_pkg::work_t wr_data_o
);
  localparam int unsigned W = ratalu_pkg::OperandWidth;
  localparam int unsigned M = ratalu_pkg::MagWidth;

  // 0 idle, 1 products, 2 combine
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul = 2'd1;
  localparam logic [1:0] StSum = 2'd2;

  logic [1:0] st_q, st_d;
  logic [1:0] kind_q;
  logic [W-1:0] na_q, da_q, nb_q, db_q;
  logic sa_q, sb_q, sd_q, sna_q, snb_q, sda_q, sdb_q;
  logic [M-1:0] pa_q, pb_q, pd_q;
  ratalu_pkg::work_t out_q;
  logic out_v_q;

  function automatic logic [W:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  logic [W:0] mna, mda, mnb, mdb;
  assign mna = mag_of(num_a_i);
  assign mda = mag_of(den_a_i);
  assign mnb = mag_of(num_b_i);
  assign mdb = mag_of(den_b_i);

  assign in_ready_o = (st_q == StIdle) && !out_v_q;
  assign wr_valid_o = out_v_q;
  assign wr_data_o = out_q;

  // product operand selection per kind
  logic [W-1:0] x0, y0, x1, y1;
  logic [M-1:0] p0, p1;
  always_comb begin
    x0 = na_q; y0 = db_q; x1 = da_q; y1 = nb_q;
    if (kind_q == ratalu_pkg::KindMul) begin
      y0 = nb_q;
    end
    p0 = M'(x0) * M'(y0);
    p1 = M'(x1) * M'(y1);
  end

  logic [M-1:0] sum_mag;
  logic sum_neg, t_neg;
  always_comb begin
    t_neg = sb_q ^ (kind_q == ratalu_pkg::KindSub);
    if (sa_q == t_neg) begin
      sum_mag = pa_q + pb_q;
      sum_neg = sa_q;
    end else if (pa_q >= pb_q) begin
      sum_mag = pa_q - pb_q;
      sum_neg = sa_q;
    end else begin
      sum_mag = pb_q - pa_q;
      sum_neg = t_neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_valid_i && in_ready_o) st_d = StMul;
      StMul: st_d = StSum;
      StSum: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StSum) out_v_q <= 1'b1;
      else if (wr_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      na_q <= mna[W-1:0]; da_q <= mda[W-1:0];
      nb_q <= mnb[W-1:0]; db_q <= mdb[W-1:0];
      // magnitude of -2^(W-1) keeps only its top bit, still exact
      sna_q <= num_a_i[W-1]; snb_q <= num_b_i[W-1];
      sda_q <= den_a_i[W-1]; sdb_q <= den_b_i[W-1];
    end
    if (st_q == StMul) begin
      pa_q <= p0;
      pb_q <= p1;
      sa_q <= (p0 != '0) &&
              (sna_q ^ ((kind_q == ratalu_pkg::KindMul) ? snb_q : sdb_q));
      sb_q <= (p1 != '0) && (sda_q ^ snb_q);
      if (kind_q == ratalu_pkg::KindDiv) begin
        pd_q <= M'(da_q) * M'(nb_q);
        sd_q <= ((M'(da_q) * M'(nb_q)) != '0) && (sda_q ^ snb_q);
      end else begin
        pd_q <= M'(da_q) * M'(db_q);
        sd_q <= ((M'(da_q) * M'(db_q)) != '0) && (sda_q ^ sdb_q);
      end
    end
    if (st_q == StSum) begin
      out_q.den_mag <= pd_q;
      out_q.den_neg <= sd_q;
      if (kind_q == ratalu_pkg::KindAdd || kind_q == ratalu_pkg::KindSub) begin
        out_q.num_mag <= sum_mag;
        out_q.num_neg <= sum_neg;
      end else begin
        out_q.num_mag <= pa_q;
        out_q.num_neg <= sa_q;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/ratalu_fifo.sv
// Two-entry queue between front and back.
`default_nettype none
module ratalu_fifo (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic wr_ready_o,
  input  wire ratalu_pkg::work_t wr_data_i,
  output logic rd_valid_o,
  input  wire logic rd_ready_i,
  output ratalu_pkg::work_t rd_data_o
);
  ratalu_pkg::work_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

### rtl/ratalu_back.sv
// Back end: binary GCD, two serial divisions, range check and output register.
`default_nettype none
module ratalu_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic rd_valid_i,
  output logic rd_ready_o,
  input  wire ratalu_pkg::work_t rd_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [31:0] num_out_o,
  output logic [31:0] den_out_o,
  output logic [1:0] status_o
);
  localparam int unsigned W = ratalu_pkg::OperandWidth;
  localparam int unsigned M = ratalu_pkg::MagWidth;
  localparam int unsigned SW = ratalu_pkg::ShWidth;
  localparam int unsigned CW = $clog2(M);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StStrip = 3'd1;
  localparam logic [2:0] StLoop = 3'd2;
  localparam logic [2:0] StDivN = 3'd3;
  localparam logic [2:0] StDivD = 3'd4;
  localparam logic [2:0] StFin = 3'd5;

  logic [2:0] st_q, st_d;
  logic [M-1:0] nm_q, dm_q, x_q, y_q, g_q, rem_q, quo_q, qn_q;
  logic nn_q, dn_q;
  logic [SW-1:0] sh_q;
  logic [CW-1:0] cnt_q;
  logic ov_q;
  logic [31:0] no_q, do_q;
  logic [1:0] stat_q;

  assign rd_ready_o = (st_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign num_out_o = no_q;
  assign den_out_o = do_q;
  assign status_o = stat_q;

  // restoring division step
  logic [M:0] trial;
  logic [M-1:0] rem_sh;
  assign rem_sh = {rem_q[M-2:0], quo_q[M-1]};
  assign trial = {rem_q[M-1], rem_sh} - {1'b0, g_q};

  logic [M-1:0] ysub;
  logic xgy;
  assign xgy = x_q > y_q;

  function automatic logic fits(input logic [M-1:0] mag, input logic neg);
    logic [M-1:0] lim;
    lim = M'(1) << (W - 1);
    return neg ? (mag <= lim) : (mag < lim);
  endfunction

  function automatic logic [31:0] to_field(input logic [M-1:0] mag, input logic neg);
    logic [W-1:0] v;
    v = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
    return {{(32 - W){v[W-1]}}, v};
  endfunction

  always_comb begin
    ysub = y_q - x_q;
    st_d = st_q;
    unique case (st_q)
      StIdle: if (rd_valid_i && rd_ready_o) st_d = StStrip;
      StStrip: begin
        if (dm_q == '0) st_d = StFin;
        else if (nm_q == '0) st_d = StDivN;
        else if (x_q[0] || y_q[0]) st_d = StLoop;
      end
      StLoop: if (y_q == '0 && x_q[0]) st_d = StDivN;
      StDivN: if (cnt_q == '0) st_d = StDivD;
      StDivD: if (cnt_q == '0) st_d = StFin;
      StFin: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StFin) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (rd_valid_i && rd_ready_o) begin
          nm_q <= rd_data_i.num_mag; nn_q <= rd_data_i.num_neg;
          dm_q <= rd_data_i.den_mag; dn_q <= rd_data_i.den_neg;
          x_q <= rd_data_i.num_mag; y_q <= rd_data_i.den_mag;
          sh_q <= '0;
        end
      end
      StStrip: begin
        if (nm_q == '0) begin
          g_q <= dm_q;
        end else if (!(x_q[0] || y_q[0])) begin
          x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 1'b1;
        end
        rem_q <= '0; quo_q <= nm_q; cnt_q <= CW'(M - 1);
      end
      StLoop: begin
        // x made odd first, then y reduced; one shift or subtract per cycle
        if (!x_q[0]) x_q <= x_q >> 1;
        else if (y_q == '0) begin
          g_q <= x_q << sh_q;
        end else if (!y_q[0]) y_q <= y_q >> 1;
        else if (xgy) begin
          x_q <= y_q; y_q <= x_q - y_q;
        end else y_q <= ysub;
        rem_q <= '0; quo_q <= nm_q; cnt_q <= CW'(M - 1);
      end
      StDivN, StDivD: begin
        if (!trial[M]) rem_q <= trial[M-1:0];
        else rem_q <= rem_sh;
        quo_q <= {quo_q[M-2:0], ~trial[M]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_q <= '0;
          quo_q <= dm_q;
          cnt_q <= CW'(M - 1);
          if (st_q == StDivN) qn_q <= {quo_q[M-2:0], ~trial[M]};
          else x_q <= {quo_q[M-2:0], ~trial[M]};
        end
      end
      StFin: begin
        no_q <= '0; do_q <= '0;
        if (dm_q == '0) stat_q <= ratalu_pkg::StatusZeroDen;
        else if (!fits(qn_q, nn_q) || !fits(x_q, dn_q))
          stat_q <= ratalu_pkg::StatusOverflow;
        else begin
          stat_q <= ratalu_pkg::StatusOk;
          no_q <= to_field(qn_q, nn_q);
          do_q <= to_field(x_q, dn_q);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/rational_alu_with_reduction_unit.sv
// Top level of the rational ALU with GCD reduction.
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o  | kind, num_a, den_a, num_b, den_b
//  out     | output    | out_valid_o / out_ready_i | num_out, den_out, status
// In the front an item passes the product and combine states and then waits in a
// two-entry queue. The back runs a binary GCD (shift/subtract steps on 64-bit
// magnitudes) and two restoring divisions over the full magnitude width; the
// length of the GCD loop depends on the operands.
// A zero denominator skips both and goes from the strip state straight to the final state.
// Reset clears all control state; no clearing pass. Each side stalls on its own.
`default_nettype none
module rational_alu_with_reduction_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [31:0] num_a_i,
  input  wire logic [31:0] den_a_i,
  input  wire logic [31:0] num_b_i,
  input  wire logic [31:0] den_b_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [31:0] num_out_o,
  output logic [31:0] den_out_o,
  output logic [1:0] status_o
);
  logic f_valid, f_ready, b_valid, b_ready;
  ratalu_pkg::work_t f_data, b_data;

  ratalu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .num_a_i, .den_a_i,
    .num_b_i, .den_b_i, .wr_valid_o(f_valid), .wr_ready_i(f_ready),
    .wr_data_o(f_data)
  );

  ratalu_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i(f_data), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o(b_data)
  );

  ratalu_back u_back (
    .clk_i, .rst_ni, .rd_valid_i(b_valid), .rd_ready_o(b_ready),
    .rd_data_i(b_data), .out_valid_o, .out_ready_i, .num_out_o, .den_out_o,
    .status_o
  );
endmodule
`default_nettype wire

### sim/tb_rational_alu_with_reduction_unit.sv
// Testbench for the rational ALU: random and directed fractions, predicted results checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_alu_with_reduction_unit;

  typedef struct {
    ratalu_pkg::kind_e kind;
    logic [31:0] na, da, nb, db;
  } frac_op_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    ratalu_pkg::status_e status;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic [31:0] num_a_i = '0, den_a_i = '0, num_b_i = '0, den_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] num_out_o, den_out_o;
  logic [1:0] status_o;

  frac_op_t pending_ops[$];
  frac_res_t expected_fracs[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0, n_checked = 0;
  int unsigned n_zero_den = 0, n_ovf = 0;
  longint unsigned cycles = 0;
  int unsigned send_gap = 0, recv_gap = 0;

  always #4 clk_i = ~clk_i;

  rational_alu_with_reduction_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .num_a_i, .den_a_i, .num_b_i, .den_b_i,
    .out_valid_o, .out_ready_i, .num_out_o, .den_out_o, .status_o
  );

  // magnitude of a 32-bit two's complement value, exact for -2^31
  function automatic logic [63:0] mag32(input logic [31:0] v);
    logic [31:0] t;
    t = v[31] ? (~v + 32'd1) : v;
    return {32'd0, t};
  endfunction

  // exact product in sign-magnitude, 64-bit magnitudes
  function automatic void smul(input bit xn, input logic [63:0] xm, input bit yn,
                               input logic [63:0] ym, output bit rn,
                               output logic [63:0] rm);
    rm = xm * ym;
    rn = (rm != 0) && (xn != yn);
  endfunction

  function automatic void sadd(input bit xn, input logic [63:0] xm, input bit yn,
                               input logic [63:0] ym, output bit rn,
                               output logic [63:0] rm);
    if (xn == yn) begin
      rm = xm + ym; rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym; rn = xn;
    end else begin
      rm = ym - xm; rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    if (x == 0) return y;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_frac(input frac_op_t op);
    frac_res_t r;
    bit sa, sda, sb, sdb, nn, dn, tn, pn;
    logic [63:0] ma, mda, mb, mdb, nm, dm, tm, pm, g;
    sa = op.na[31]; ma = mag32(op.na);
    sda = op.da[31]; mda = mag32(op.da);
    sb = op.nb[31]; mb = mag32(op.nb);
    sdb = op.db[31]; mdb = mag32(op.db);
    case (op.kind)
      ratalu_pkg::KindAdd, ratalu_pkg::KindSub: begin
        smul(sa, ma, sdb, mdb, pn, pm);
        smul(sda, mda, sb, mb, tn, tm);
        if (op.kind == ratalu_pkg::KindSub) tn = (tm != 0) && !tn;
        sadd(pn, pm, tn, tm, nn, nm);
        smul(sda, mda, sdb, mdb, dn, dm);
      end
      ratalu_pkg::KindMul: begin
        smul(sa, ma, sb, mb, nn, nm);
        smul(sda, mda, sdb, mdb, dn, dm);
      end
      default: begin
        smul(sa, ma, sdb, mdb, nn, nm);
        smul(sda, mda, sb, mb, dn, dm);
      end
    endcase
    r.num = '0; r.den = '0;
    if (dm == 0) begin
      r.status = ratalu_pkg::StatusZeroDen;
      return r;
    end
    g = gcd64(nm, dm);
    nm = nm / g; dm = dm / g;
    if ((nn ? nm > 64'h8000_0000 : nm >= 64'h8000_0000) ||
        (dn ? dm > 64'h8000_0000 : dm >= 64'h8000_0000)) begin
      r.status = ratalu_pkg::StatusOverflow;
      return r;
    end
    r.num = nn ? 32'(-nm) : 32'(nm);
    r.den = dn ? 32'(-dm) : 32'(dm);
    r.status = ratalu_pkg::StatusOk;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
  endtask

  // random operand, biased toward small and edge values
  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(0, 40)) - 20);
      5, 6: return 32'($signed($urandom_range(0, 2000)) - 1000);
      7: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input ratalu_pkg::kind_e k, input logic [31:0] a, b, c, d);
    frac_op_t op;
    op.kind = k; op.na = a; op.da = b; op.nb = c; op.db = d;
    pending_ops.push_back(op);
  endtask

  // driver
  always @(posedge clk_i) begin
    frac_op_t op;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        n_sent++;
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 9);
      end else if (!in_valid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          expected_fracs.push_back(reduce_frac(op));
          if (expected_fracs[$].status == ratalu_pkg::StatusZeroDen) n_zero_den++;
          if (expected_fracs[$].status == ratalu_pkg::StatusOverflow) n_ovf++;
          kind_i <= op.kind; num_a_i <= op.na; den_a_i <= op.da;
          num_b_i <= op.nb; den_b_i <= op.db;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && out_ready_i) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected result", num_out_o, '0);
        end else begin
          frac_res_t e;
          e = expected_fracs.pop_front();
          if (num_out_o !== e.num) report_mismatch("num_out", num_out_o, e.num);
          if (den_out_o !== e.den) report_mismatch("den_out", den_out_o, e.den);
          if (status_o !== e.status) report_mismatch("status", 32'(status_o), 32'(e.status));
        end
        n_checked++;
        recv_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
        out_ready_i <= (recv_gap == 0);
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= (recv_gap == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
      if (cycles > 3_000_000) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] ext[6];
    int unsigned i;
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h5555_aaaa};
    // directed: every kind, extremes, zero denominators, zero numerator, overflow
    push_op(ratalu_pkg::KindAdd, 1, 2, 1, 3);
    push_op(ratalu_pkg::KindSub, 1, 2, 1, 2);
    push_op(ratalu_pkg::KindSub, 0, -3, 0, 5);
    push_op(ratalu_pkg::KindMul, 2, 4, 3, 9);
    push_op(ratalu_pkg::KindDiv, 1, 2, 0, 3);
    push_op(ratalu_pkg::KindDiv, 3, -4, 5, 7);
    push_op(ratalu_pkg::KindAdd, 1, 0, 1, 2);
    push_op(ratalu_pkg::KindMul, 1, 2, 1, 0);
    push_op(ratalu_pkg::KindMul, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    push_op(ratalu_pkg::KindMul, 32'h8000_0000, 1, 1, 1);
    push_op(ratalu_pkg::KindMul, 32'h8000_0000, 1, -1, 1);
    push_op(ratalu_pkg::KindAdd, 32'h8000_0000, 1, 32'h8000_0000, 1);
    push_op(ratalu_pkg::KindDiv, 0, 32'h8000_0000, -1, 32'h7fff_ffff);
    for (i = 0; i < 12; i++)
      push_op(ratalu_pkg::kind_e'(i % 4), ext[i % 6], ext[(i + 1) % 6],
              ext[(i + 3) % 6], ext[(i + 5) % 6]);
    for (i = 0; i < 1300; i++)
      push_op(ratalu_pkg::kind_e'($urandom_range(0, 3)), pick_val(), pick_val(),
              pick_val(), pick_val());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && !in_valid_i);
    wait (expected_fracs.size() == 0);
    repeat (500) @(posedge clk_i);
    $display("sent %0d fraction ops, checked %0d results", n_sent, n_checked);
    $display("  of them %0d zero-denominator, %0d overflow", n_zero_den, n_ovf);
    if (errors == 0 && expected_fracs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
